FILE: rtl/core/tccg_pkg.sv
package tccg_pkg;

  // angle constants, Q30 radians
  localparam logic [33:0] HALF_PI_Q30      = 34'd1686629713;
  localparam logic [33:0] QTR_PI_Q30       = 34'd843314856;
  localparam logic [33:0] FOUR_HALF_PI_Q30 = 34'd6746518852;
  localparam logic [30:0] ONE_Q30          = 31'd1073741824;

  localparam int HORNER_STEPS = 6;
  localparam int SQRT_STEPS   = 30;
  localparam int DIV_STEPS    = 22;
  localparam int PIPE_LATENCY = 75;

  // register reset values
  localparam logic [19:0] TIRE_WIDTH_RST      = 20'd188744;
  localparam logic [17:0] LATERAL_RATIO_RST   = 18'd32768;
  localparam logic [17:0] RADIAL_RATIO_RST    = 18'd32768;
  localparam logic [20:0] UNLOADED_RADIUS_RST = 21'd314573;

  // profile limits
  localparam logic [19:0] WIDTH_LO      = 20'd20971;
  localparam logic [19:0] WIDTH_HI      = 20'd838860;
  localparam logic [17:0] RATIO_LO      = 18'd655;
  localparam logic [17:0] RATIO_HI      = 18'd131072;
  localparam logic [20:0] RADIUS_HI     = 21'd1572864;
  localparam logic [22:0] RADIUS_MARGIN = 23'd10485;

  typedef enum logic [2:0] {
    REG_TIRE_WIDTH      = 3'd0,
    REG_LATERAL_RATIO   = 3'd1,
    REG_RADIAL_RATIO    = 3'd2,
    REG_UNLOADED_RADIUS = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        sneg;
    logic        cneg;
    logic [30:0] smag;
    logic [30:0] cmag;
  } sc_t;

  typedef struct packed {
    logic        sneg;
    logic        cneg;
    logic [49:0] pa;
    logic [49:0] pb;
    logic [28:0] term;
  } sq_side_t;

  typedef struct packed {
    logic               sneg;
    logic               cneg;
    logic               sup_nz;
    logic signed [31:0] ctr;
  } div_side_t;

  function automatic int unsigned sin_div(input int i);
    int unsigned d;
    case (i)
      0: d = 156;
      1: d = 110;
      2: d = 72;
      3: d = 42;
      4: d = 20;
      default: d = 6;
    endcase
    return d;
  endfunction

  function automatic int unsigned cos_div(input int i);
    int unsigned d;
    case (i)
      0: d = 132;
      1: d = 90;
      2: d = 56;
      3: d = 30;
      4: d = 12;
      default: d = 2;
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/core/tccg_sincos.sv
module tccg_sincos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [18:0] in_angle,
  output logic               out_valid,
  output tccg_pkg::sc_t      out_sc
);
  import tccg_pkg::*;

  typedef struct packed {
    logic [29:0] t;
    logic [29:0] t2;
    logic        rneg;
    logic [2:0]  k;
  } hside_t;

  localparam int NST = 2 * HORNER_STEPS;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v18_r, v19_r;
  logic [33:0]        x1_nxt, x1_r, x2_r, kpi;
  logic [2:0]         k2_nxt, k2_r, k3_r, k4_r, k18_r;
  logic [33:0]        r_full;
  logic signed [30:0] r3_r;
  logic [29:0]        t4_nxt, t4_r;
  logic               rneg4_r;
  hside_t             s5_nxt, s5_r;

  hside_t      sd_r  [NST];
  hside_t      sd_in [NST];
  logic        hv_r  [NST];
  logic        hv_in [NST];
  logic [29:0] ps_r [HORNER_STEPS], pc_r [HORNER_STEPS];
  logic [29:0] ps_nxt [HORNER_STEPS], pc_nxt [HORNER_STEPS];
  logic [30:0] hs_r [HORNER_STEPS], hc_r [HORNER_STEPS];
  logic [30:0] hs_nxt [HORNER_STEPS], hc_nxt [HORNER_STEPS];
  logic [30:0] hs_in [HORNER_STEPS], hc_in [HORNER_STEPS];

  logic [29:0] sm18_nxt, sm18_r;
  logic [30:0] cm18_r;
  logic        rneg18_r;
  logic        smz;
  sc_t         sc_nxt, sc_r;

  // shift the Q16 angle to Q30 and offset by 2*pi so it stays positive
  assign x1_nxt = ({{15{in_angle[18]}}, in_angle} << 14) + FOUR_HALF_PI_Q30;

  // nearest multiple of pi/2
  always_comb begin
    k2_nxt = '0;
    for (int j = 1; j <= 7; j++) begin
      if (x1_r >= 34'(j) * HALF_PI_Q30 - QTR_PI_Q30) k2_nxt = k2_nxt + 3'd1;
    end
  end

  assign kpi    = 34'(k2_r) * HALF_PI_Q30;
  assign r_full = x2_r - kpi;
  assign t4_nxt = r3_r[30] ? 30'(-r3_r) : 30'(r3_r);

  always_comb begin
    s5_nxt.t    = t4_r;
    s5_nxt.t2   = 30'((60'(t4_r) * 60'(t4_r) + (60'd1 << 29)) >> 30);
    s5_nxt.rneg = rneg4_r;
    s5_nxt.k    = k4_r;
  end

  for (genvar j = 0; j < NST; j++) begin : g_side
    if (j == 0) begin : g_first
      assign sd_in[j] = s5_r;
      assign hv_in[j] = v5_r;
    end else begin : g_next
      assign sd_in[j] = sd_r[j-1];
      assign hv_in[j] = hv_r[j-1];
    end
  end

  // Horner steps: multiply stage, then divide-by-constant stage
  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
    localparam int unsigned DS  = sin_div(i);
    localparam int unsigned DC  = cos_div(i);
    localparam int          SHS = 30 + $clog2(DS);
    localparam int          SHC = 30 + $clog2(DC);
    localparam logic [31:0] MS  = 32'((64'd1 << SHS) / 64'(DS) + 64'd1);
    localparam logic [31:0] MC  = 32'((64'd1 << SHC) / 64'(DC) + 64'd1);

    if (i == 0) begin : g_first
      assign hs_in[i] = ONE_Q30;
      assign hc_in[i] = ONE_Q30;
    end else begin : g_next
      assign hs_in[i] = hs_r[i-1];
      assign hc_in[i] = hc_r[i-1];
    end

    assign ps_nxt[i] = 30'((61'(sd_in[2*i].t2) * 61'(hs_in[i])) >> 30);
    assign pc_nxt[i] = 30'((61'(sd_in[2*i].t2) * 61'(hc_in[i])) >> 30);
    assign hs_nxt[i] = ONE_Q30 - 31'((62'(ps_r[i]) * 62'(MS)) >> SHS);
    assign hc_nxt[i] = ONE_Q30 - 31'((62'(pc_r[i]) * 62'(MC)) >> SHC);
  end

  assign sm18_nxt = 30'((61'(sd_r[NST-1].t) * 61'(hs_r[HORNER_STEPS-1])) >> 30);

  // quadrant: swap and sign
  assign smz = (sm18_r != '0);
  always_comb begin
    case (k18_r[1:0])
      2'd0: begin
        sc_nxt.sneg = rneg18_r & smz;
        sc_nxt.cneg = 1'b0;
        sc_nxt.smag = {1'b0, sm18_r};
        sc_nxt.cmag = cm18_r;
      end
      2'd1: begin
        sc_nxt.sneg = 1'b0;
        sc_nxt.cneg = ~rneg18_r & smz;
        sc_nxt.smag = cm18_r;
        sc_nxt.cmag = {1'b0, sm18_r};
      end
      2'd2: begin
        sc_nxt.sneg = ~rneg18_r & smz;
        sc_nxt.cneg = (cm18_r != '0);
        sc_nxt.smag = {1'b0, sm18_r};
        sc_nxt.cmag = cm18_r;
      end
      default: begin
        sc_nxt.sneg = (cm18_r != '0);
        sc_nxt.cneg = rneg18_r & smz;
        sc_nxt.smag = cm18_r;
        sc_nxt.cmag = {1'b0, sm18_r};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      v5_r  <= 1'b0;
      v18_r <= 1'b0;
      v19_r <= 1'b0;
      for (int j = 0; j < NST; j++) hv_r[j] <= 1'b0;
    end else begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      for (int j = 0; j < NST; j++) hv_r[j] <= hv_in[j];
      v18_r <= hv_r[NST-1];
      v19_r <= v18_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r     <= x1_nxt;
    x2_r     <= x1_r;
    k2_r     <= k2_nxt;
    k3_r     <= k2_r;
    r3_r     <= signed'(r_full[30:0]);
    k4_r     <= k3_r;
    t4_r     <= t4_nxt;
    rneg4_r  <= r3_r[30];
    s5_r     <= s5_nxt;
    for (int j = 0; j < NST; j++) sd_r[j] <= sd_in[j];
    for (int i = 0; i < HORNER_STEPS; i++) begin
      ps_r[i] <= ps_nxt[i];
      pc_r[i] <= pc_nxt[i];
      hs_r[i] <= hs_nxt[i];
      hc_r[i] <= hc_nxt[i];
    end
    sm18_r   <= sm18_nxt;
    cm18_r   <= hc_r[HORNER_STEPS-1];
    rneg18_r <= sd_r[NST-1].rneg;
    k18_r    <= sd_r[NST-1].k;
    sc_r     <= sc_nxt;
  end

  assign out_valid = v19_r;
  assign out_sc    = sc_r;

endmodule

FILE: rtl/core/tccg_isqrt.sv
module tccg_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [58:0]         in_rad,
  input  tccg_pkg::sq_side_t  in_side,
  output logic                out_valid,
  output logic [29:0]         out_root,
  output tccg_pkg::sq_side_t  out_side
);
  import tccg_pkg::*;

  logic [59:0] v_r     [SQRT_STEPS];
  logic [59:0] res_r   [SQRT_STEPS];
  logic [59:0] v_in    [SQRT_STEPS];
  logic [59:0] res_in  [SQRT_STEPS];
  logic [59:0] v_nxt   [SQRT_STEPS];
  logic [59:0] res_nxt [SQRT_STEPS];
  sq_side_t    side_r  [SQRT_STEPS];
  sq_side_t    side_in [SQRT_STEPS];
  logic        val_r   [SQRT_STEPS];
  logic        val_in  [SQRT_STEPS];

  // one result bit per stage, restoring
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
    localparam logic [59:0] BIT = 60'd1 << (58 - 2 * i);
    logic [59:0] trial;
    logic        take;

    if (i == 0) begin : g_first
      assign v_in[i]    = {1'b0, in_rad};
      assign res_in[i]  = '0;
      assign side_in[i] = in_side;
      assign val_in[i]  = in_valid;
    end else begin : g_next
      assign v_in[i]    = v_r[i-1];
      assign res_in[i]  = res_r[i-1];
      assign side_in[i] = side_r[i-1];
      assign val_in[i]  = val_r[i-1];
    end

    assign trial      = res_in[i] + BIT;
    assign take       = (v_in[i] >= trial);
    assign v_nxt[i]   = take ? v_in[i] - trial : v_in[i];
    assign res_nxt[i] = take ? (res_in[i] >> 1) + BIT : res_in[i] >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SQRT_STEPS; i++) val_r[i] <= 1'b0;
    end else begin
      for (int i = 0; i < SQRT_STEPS; i++) val_r[i] <= val_in[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQRT_STEPS; i++) begin
      v_r[i]    <= v_nxt[i];
      res_r[i]  <= res_nxt[i];
      side_r[i] <= side_in[i];
    end
  end

  assign out_valid = val_r[SQRT_STEPS-1];
  assign out_root  = res_r[SQRT_STEPS-1][29:0];
  assign out_side  = side_r[SQRT_STEPS-1];

endmodule

FILE: rtl/core/tccg_div.sv
module tccg_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [50:0]         in_num_a,
  input  logic [50:0]         in_num_b,
  input  logic [30:0]         in_den_a,
  input  logic [30:0]         in_den_b,
  input  tccg_pkg::div_side_t in_side,
  output logic                out_valid,
  output logic [21:0]         out_quo_a,
  output logic [21:0]         out_quo_b,
  output tccg_pkg::div_side_t out_side
);
  import tccg_pkg::*;

  // two lanes side by side, one quotient bit per stage, MSB first
  logic [50:0] rem_r   [DIV_STEPS][2];
  logic [50:0] rem_in  [DIV_STEPS][2];
  logic [50:0] rem_nxt [DIV_STEPS][2];
  logic [30:0] den_r   [DIV_STEPS][2];
  logic [30:0] den_in  [DIV_STEPS][2];
  logic [21:0] q_r     [DIV_STEPS][2];
  logic [21:0] q_in    [DIV_STEPS][2];
  logic [21:0] q_nxt   [DIV_STEPS][2];
  div_side_t   side_r  [DIV_STEPS];
  div_side_t   side_in [DIV_STEPS];
  logic        val_r   [DIV_STEPS];
  logic        val_in  [DIV_STEPS];
  logic [50:0] num_p   [2];
  logic [30:0] den_p   [2];

  assign num_p[0] = in_num_a;
  assign num_p[1] = in_num_b;
  assign den_p[0] = in_den_a;
  assign den_p[1] = in_den_b;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
    localparam int QB = DIV_STEPS - 1 - j;

    if (j == 0) begin : g_first
      assign side_in[j] = in_side;
      assign val_in[j]  = in_valid;
    end else begin : g_next
      assign side_in[j] = side_r[j-1];
      assign val_in[j]  = val_r[j-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [51:0] trial;
      logic        take;

      if (j == 0) begin : g_first
        assign rem_in[j][l] = num_p[l];
        assign den_in[j][l] = den_p[l];
        assign q_in[j][l]   = '0;
      end else begin : g_next
        assign rem_in[j][l] = rem_r[j-1][l];
        assign den_in[j][l] = den_r[j-1][l];
        assign q_in[j][l]   = q_r[j-1][l];
      end

      assign trial         = 52'(den_in[j][l]) << QB;
      assign take          = (52'(rem_in[j][l]) >= trial);
      assign rem_nxt[j][l] = take ? 51'(52'(rem_in[j][l]) - trial) : rem_in[j][l];
      assign q_nxt[j][l]   = q_in[j][l] | (22'(take) << QB);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < DIV_STEPS; j++) val_r[j] <= 1'b0;
    end else begin
      for (int j = 0; j < DIV_STEPS; j++) val_r[j] <= val_in[j];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      side_r[j] <= side_in[j];
      for (int l = 0; l < 2; l++) begin
        rem_r[j][l] <= rem_nxt[j][l];
        den_r[j][l] <= den_in[j][l];
        q_r[j][l]   <= q_nxt[j][l];
      end
    end
  end

  assign out_valid = val_r[DIV_STEPS-1];
  assign out_quo_a = q_r[DIV_STEPS-1][0];
  assign out_quo_b = q_r[DIV_STEPS-1][1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

FILE: rtl/core/tire_crown_contact_geometry.sv
// Contact point of an elliptic tire crown on a flat road for a given camber angle. A request
// is taken on every clock edge with start high (busy is never raised) and its result shows on
// the out_ ports for one cycle with out_valid; results come out in request order and cannot
// be held off. The pipeline holds 19 stages of angle reduction and sine/cosine Horner steps,
// 2 multiply stages, 30 stages of the square root (one root bit each), one setup stage,
// 22 stages of the two offset dividers (one quotient bit each) and the output register.
// Configuration registers reach the derived semi-axes through the a_r/b_r registers, and
// the crown base radius and the validity flag through a further register behind those.
module tire_crown_contact_geometry (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [18:0] in_camber_angle,
  output logic               out_valid,
  output logic               out_geometry_valid,
  output logic [20:0]        out_lateral_semi_axis,
  output logic [20:0]        out_radial_semi_axis,
  output logic [20:0]        out_crown_base_radius,
  output logic signed [21:0] out_lateral_offset,
  output logic signed [21:0] out_radial_offset,
  output logic [21:0]        out_centre_to_road,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [20:0]        cfg_wdata
);
  import tccg_pkg::*;

  logic [19:0] tire_width_r;
  logic [17:0] lateral_ratio_r, radial_ratio_r;
  logic [20:0] unloaded_radius_r;
  logic [21:0] a_nxt, b_nxt, a_r, b_r;
  logic        prof_ok_nxt, prof_ok_r;
  logic [20:0] base_r;

  logic        trig_valid;
  sc_t         trig_sc;

  logic        v20_r, v21_r;
  logic [28:0] asf_r, bcf_r, term20_r;
  logic        sneg20_r, cneg20_r;
  logic [58:0] rad_sum_r;
  sq_side_t    sq_side_r;

  logic        sq_valid;
  logic [29:0] sq_root;
  sq_side_t    sq_side;

  logic        v52_r;
  logic [50:0] num_a_r, num_b_r;
  logic [30:0] den_a_r, den_b_r;
  div_side_t   dside_nxt, dside_r;

  logic        dv_valid;
  logic [21:0] quo_a, quo_b;
  div_side_t   dv_side;

  logic        ok;
  logic [31:0] ctr_pos;
  logic [21:0] ctr_out;
  logic        out_valid_r, geom_valid_r;
  logic [20:0] lat_axis_r, rad_axis_r, base_out_r;
  logic [21:0] lat_off_r, rad_off_r, ctr_r;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tire_width_r      <= TIRE_WIDTH_RST;
      lateral_ratio_r   <= LATERAL_RATIO_RST;
      radial_ratio_r    <= RADIAL_RATIO_RST;
      unloaded_radius_r <= UNLOADED_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIRE_WIDTH:      tire_width_r      <= cfg_wdata[19:0];
        REG_LATERAL_RATIO:   lateral_ratio_r   <= cfg_wdata[17:0];
        REG_RADIAL_RATIO:    radial_ratio_r    <= cfg_wdata[17:0];
        REG_UNLOADED_RADIUS: unloaded_radius_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // semi-axes, rounded half up
  assign a_nxt = 22'((38'(lateral_ratio_r) * 38'(tire_width_r) + 38'd32768) >> 16);
  assign b_nxt = 22'((38'(radial_ratio_r) * 38'(tire_width_r) + 38'd32768) >> 16);

  assign prof_ok_nxt = (tire_width_r > WIDTH_LO) && (tire_width_r <= WIDTH_HI)
                    && (lateral_ratio_r > RATIO_LO) && (lateral_ratio_r <= RATIO_HI)
                    && (radial_ratio_r > RATIO_LO) && (radial_ratio_r <= RATIO_HI)
                    && (23'(unloaded_radius_r) > 23'(b_r) + RADIUS_MARGIN)
                    && (unloaded_radius_r < RADIUS_HI)
                    && (a_r != '0) && (b_r != '0);

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    prof_ok_r <= prof_ok_nxt;
    base_r    <= 21'(unloaded_radius_r - b_r[20:0]);
  end

  tccg_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_angle  (in_camber_angle),
    .out_valid (trig_valid),
    .out_sc    (trig_sc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v20_r <= 1'b0;
      v21_r <= 1'b0;
      v52_r <= 1'b0;
    end else begin
      v20_r <= trig_valid;
      v21_r <= v20_r;
      v52_r <= sq_valid;
    end
  end

  // scale sin/cos by the axes, 2^-28 m
  always_ff @(posedge clk) begin
    asf_r    <= 29'((52'(a_r[20:0]) * 52'(trig_sc.smag) + (52'd1 << 21)) >> 22);
    bcf_r    <= 29'((52'(b_r[20:0]) * 52'(trig_sc.cmag) + (52'd1 << 21)) >> 22);
    term20_r <= 29'((52'(base_r) * 52'(trig_sc.cmag) + (52'd1 << 21)) >> 22);
    sneg20_r <= trig_sc.sneg;
    cneg20_r <= trig_sc.cneg;
  end

  always_ff @(posedge clk) begin
    rad_sum_r      <= 59'(58'(asf_r) * 58'(asf_r)) + 59'(58'(bcf_r) * 58'(bcf_r));
    sq_side_r.sneg <= sneg20_r;
    sq_side_r.cneg <= cneg20_r;
    sq_side_r.pa   <= 50'(a_r[20:0]) * 50'(asf_r);
    sq_side_r.pb   <= 50'(b_r[20:0]) * 50'(bcf_r);
    sq_side_r.term <= term20_r;
  end

  tccg_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v21_r),
    .in_rad    (rad_sum_r),
    .in_side   (sq_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  always_comb begin
    dside_nxt.sneg   = sq_side.sneg;
    dside_nxt.cneg   = sq_side.cneg;
    dside_nxt.sup_nz = (sq_root != '0);
    dside_nxt.ctr    = sq_side.cneg ? signed'(32'(sq_root)) - signed'(32'(sq_side.term))
                                    : signed'(32'(sq_root)) + signed'(32'(sq_side.term));
  end

  // numerators carry the rounding half of the divisor
  always_ff @(posedge clk) begin
    num_a_r <= {sq_side.pa, 1'b0} + 51'(sq_root);
    num_b_r <= {sq_side.pb, 1'b0} + 51'(sq_root);
    den_a_r <= {sq_root, 1'b0};
    den_b_r <= {sq_root, 1'b0};
    dside_r <= dside_nxt;
  end

  tccg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v52_r),
    .in_num_a  (num_a_r),
    .in_num_b  (num_b_r),
    .in_den_a  (den_a_r),
    .in_den_b  (den_b_r),
    .in_side   (dside_r),
    .out_valid (dv_valid),
    .out_quo_a (quo_a),
    .out_quo_b (quo_b),
    .out_side  (dv_side)
  );

  assign ok      = prof_ok_r & dv_side.sup_nz;
  assign ctr_pos = 32'(dv_side.ctr);
  assign ctr_out = (dv_side.ctr <= 0) ? '0 : 22'((33'(ctr_pos) + 33'd128) >> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    geom_valid_r <= ok;
    lat_axis_r   <= ok ? a_r[20:0] : '0;
    rad_axis_r   <= ok ? b_r[20:0] : '0;
    base_out_r   <= ok ? base_r : '0;
    lat_off_r    <= !ok ? '0 : (dv_side.sneg ? quo_a : 22'd0 - quo_a);
    rad_off_r    <= !ok ? '0 : (dv_side.cneg ? quo_b : 22'd0 - quo_b);
    ctr_r        <= ok ? ctr_out : '0;
  end

  assign out_valid             = out_valid_r;
  assign out_geometry_valid    = geom_valid_r;
  assign out_lateral_semi_axis = lat_axis_r;
  assign out_radial_semi_axis  = rad_axis_r;
  assign out_crown_base_radius = base_out_r;
  assign out_lateral_offset    = signed'(lat_off_r);
  assign out_radial_offset     = signed'(rad_off_r);
  assign out_centre_to_road    = ctr_r;

endmodule

FILE: rtl/core/tccg_check.sv
module tccg_check (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [18:0] in_camber_angle,
  input logic               out_valid,
  input logic               out_geometry_valid,
  input logic [20:0]        out_lateral_semi_axis,
  input logic [20:0]        out_radial_semi_axis,
  input logic [20:0]        out_crown_base_radius,
  input logic signed [21:0] out_lateral_offset,
  input logic signed [21:0] out_radial_offset,
  input logic [21:0]        out_centre_to_road,
  input logic               cfg_we,
  input logic [2:0]         cfg_index,
  input logic [20:0]        cfg_wdata
);
  import tccg_pkg::*;

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("request produced no result");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_geometry_valid) |->
      (out_lateral_semi_axis == '0 && out_radial_semi_axis == '0 &&
       out_crown_base_radius == '0 && out_lateral_offset == '0 &&
       out_radial_offset == '0 && out_centre_to_road == '0))
    else $error("invalid geometry with nonzero fields");

  a_axes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_geometry_valid) |->
      (out_lateral_semi_axis != '0 && out_radial_semi_axis != '0 &&
       out_crown_base_radius != '0))
    else $error("valid geometry with zero axis");

endmodule

bind tire_crown_contact_geometry tccg_check u_tccg_check (.*);
